// ----- rtl/cea_pkg.sv -----
// ----------------------------------------------------------------------------
// cea_pkg
// Shared constants, codes and controller/datapath interface types for the
// contiguous entry allocator.
// ----------------------------------------------------------------------------
package cea_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int LEN_W       = 16;
  localparam int ES_W        = 13;
  localparam int EIU_W       = 7;
  localparam int STAT_W      = 2;
  localparam int BASE_W      = 6;
  localparam int OFF_W       = 18;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [ES_W-1:0]  ES_RESET  = 13'd8;
  localparam logic [ES_W-1:0]  ES_MAX    = 13'd4096;
  localparam logic [EIU_W-1:0] EIU_RESET = 7'd64;

  localparam logic [STAT_W-1:0] STAT_ALLOC = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FRAG  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SHORT = 2'd2;

  localparam logic REG_ENTRY_SIZE = 1'b0;
  localparam logic REG_ENTRIES    = 1'b1;

  typedef struct packed {
    logic clr;
    logic load;
    logic div_step;
    logic scan_step;
    logic scan_end;
    logic mark_step;
    logic mul;
  } cea_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic scan_done;
    logic scan_hit;
    logic need_zero;
    logic mark_last;
  } cea_sts_t;

endpackage

// ----- rtl/cea_ram.sv -----
// ----------------------------------------------------------------------------
// cea_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cea_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/cea_ctrl.sv -----
// ----------------------------------------------------------------------------
// cea_ctrl
// Sequencer: clearing pass, divide, bitmap scan, run marking, offset multiply.
// ----------------------------------------------------------------------------
module cea_ctrl
  import cea_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_strobe,
  output cea_cmd_t cmd,
  input  cea_sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_MARK,
    S_MUL
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.scan_end = 1'b1;
          state_nxt    = (sts.scan_hit && !sts.need_zero) ? S_MARK : S_MUL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule

// ----- rtl/cea_dp.sv -----
// ----------------------------------------------------------------------------
// cea_dp
// Datapath: restoring divider, occupancy map RAM, first-fit scan counters,
// run marking and byte offset multiply.
// ----------------------------------------------------------------------------
module cea_dp
  import cea_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int AW     = $clog2(ENTRIES),
  localparam int PW     = $clog2(ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cea_cmd_t          cmd,
  output cea_sts_t          sts,
  input  logic [LEN_W-1:0]  in_value_length,
  input  logic [ES_W-1:0]   es,
  input  logic [PW-1:0]     limit,
  output logic [STAT_W-1:0] out_status,
  output logic [BASE_W-1:0] out_base_index,
  output logic [OFF_W-1:0]  out_byte_offset,
  output logic [LEN_W-1:0]  out_entries_needed
);

  localparam int PRW = AW + ES_W;
  localparam int MW  = (PRW > OFF_W) ? PRW : OFF_W;
  localparam int BW  = (AW > BASE_W) ? AW : BASE_W;
  localparam logic [AW-1:0] ADDR_LAST = AW'(ENTRIES - 1);

  logic [LEN_W-1:0]  dq_r, dq_nxt;
  logic [ES_W-1:0]   rem_r, rem_nxt;
  logic [3:0]        div_cnt_r, div_cnt_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              rv_r, rv_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     run_r, run_nxt;
  logic [PW-1:0]     free_r, free_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [OFF_W-1:0]  offset_r, offset_nxt;

  logic [ES_W-1:0]   shifted;
  logic              fits;
  logic [LEN_W-1:0]  need;
  logic              hit;
  logic [PW-1:0]     run_start;
  logic              rbit;
  logic [MW-1:0]     prod;
  logic [BW-1:0]     base_w;

  cea_ram #(
    .WIDTH (1),
    .DEPTH (ENTRIES)
  ) u_map (
    .clk   (clk),
    .we    (cmd.clr | cmd.mark_step),
    .waddr (addr_r),
    .wdata (cmd.mark_step),
    .raddr (addr_r),
    .rdata (rbit)
  );

  assign shifted   = {rem_r[ES_W-2:0], dq_r[LEN_W-1]};
  assign fits      = (shifted >= es);
  assign need      = dq_r + LEN_W'(rem_r != '0);
  assign hit       = (LEN_W'(run_r) == need);
  assign run_start = pos_r - run_r;
  assign prod      = MW'(base_r) * MW'(es);

  assign sts.clr_last  = (addr_r == ADDR_LAST);
  assign sts.div_last  = (div_cnt_r == 4'd15);
  assign sts.scan_done = hit || (pos_r >= limit);
  assign sts.scan_hit  = hit;
  assign sts.need_zero = (need == '0);
  assign sts.mark_last = ((PW'(addr_r) + PW'(1)) == pos_r);

  always_comb begin
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    addr_nxt    = addr_r;
    rv_nxt      = rv_r;
    pos_nxt     = pos_r;
    run_nxt     = run_r;
    free_nxt    = free_r;
    base_nxt    = base_r;
    status_nxt  = status_r;
    offset_nxt  = offset_r;
    if (cmd.clr || cmd.mark_step) begin
      addr_nxt = addr_r + AW'(1);
    end
    if (cmd.load) begin
      dq_nxt      = in_value_length;
      rem_nxt     = '0;
      div_cnt_nxt = '0;
      addr_nxt    = '0;
      rv_nxt      = 1'b0;
      pos_nxt     = '0;
      run_nxt     = '0;
      free_nxt    = '0;
    end
    if (cmd.div_step) begin
      rem_nxt     = fits ? (shifted - es) : shifted;
      dq_nxt      = {dq_r[LEN_W-2:0], fits};
      div_cnt_nxt = div_cnt_r + 4'd1;
    end
    if (cmd.scan_step) begin
      addr_nxt = addr_r + AW'(1);
      rv_nxt   = 1'b1;
      if (rv_r) begin
        pos_nxt = pos_r + PW'(1);
        if (!rbit) begin
          run_nxt  = run_r + PW'(1);
          free_nxt = free_r + PW'(1);
        end else begin
          run_nxt = '0;
        end
      end
    end
    if (cmd.scan_end) begin
      addr_nxt = AW'(run_start);
      if (hit) begin
        base_nxt   = AW'(run_start);
        status_nxt = STAT_ALLOC;
      end else begin
        base_nxt   = '0;
        status_nxt = (need <= LEN_W'(free_r)) ? STAT_FRAG : STAT_SHORT;
      end
    end
    if (cmd.mul) begin
      offset_nxt = prod[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    rv_r      <= rv_nxt;
    pos_r     <= pos_nxt;
    run_r     <= run_nxt;
    free_r    <= free_nxt;
    base_r    <= base_nxt;
    status_r  <= status_nxt;
    offset_r  <= offset_nxt;
  end

  assign base_w             = BW'(base_r);
  assign out_status         = status_r;
  assign out_base_index     = base_w[BASE_W-1:0];
  assign out_byte_offset    = offset_r;
  assign out_entries_needed = need;

endmodule

// ----- rtl/contiguous_entry_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_entry_allocator
// First-fit contiguous allocator over an occupancy bitmap held in RAM.
// Start runs the 16-step divider, then the scan and run marking at one entry
// per cycle through the RAM, then the offset multiply before out_strobe.
// One word in flight; busy is high until the result cycle. After reset a
// clearing pass zeroes the map with busy high; the result side cannot stall.
// ----------------------------------------------------------------------------
module contiguous_entry_allocator
  import cea_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [LEN_W-1:0]   in_value_length,
  output logic               out_strobe,
  output logic [STAT_W-1:0]  out_status,
  output logic [BASE_W-1:0]  out_base_index,
  output logic [OFF_W-1:0]   out_byte_offset,
  output logic [LEN_W-1:0]   out_entries_needed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int PW = $clog2(ENTRIES + 1);
  localparam int LW = (PW > EIU_W) ? PW : EIU_W;

  logic [ES_W-1:0]  es_r;
  logic [EIU_W-1:0] eiu_r;
  logic [ES_W-1:0]  es_eff;
  logic [LW-1:0]    eiu_w;
  logic [PW-1:0]    limit;
  logic             reg_sel;
  cea_cmd_t         cmd;
  cea_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      es_r  <= ES_RESET;
      eiu_r <= EIU_RESET;
    end else if (psel && penable && pwrite) begin
      if (reg_sel == REG_ENTRY_SIZE) begin
        es_r <= pwdata[ES_W-1:0];
      end else begin
        eiu_r <= pwdata[EIU_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_ENTRIES) ? PDATA_W'(eiu_r) : PDATA_W'(es_r);

  assign es_eff = (es_r == '0) ? ES_W'(1) : ((es_r > ES_MAX) ? ES_MAX : es_r);
  assign eiu_w  = LW'(eiu_r);
  assign limit  = (eiu_w > LW'(ENTRIES)) ? PW'(ENTRIES) : PW'(eiu_w);

  cea_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  cea_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_value_length    (in_value_length),
    .es                 (es_eff),
    .limit              (limit),
    .out_status         (out_status),
    .out_base_index     (out_base_index),
    .out_byte_offset    (out_byte_offset),
    .out_entries_needed (out_entries_needed)
  );

endmodule
